FILE: sv/dex_class_data_stream_parser_core_assert.svh
// Assertion macros for the class data stream parser checks
`ifndef DEX_CLASS_DATA_STREAM_PARSER_CORE_ASSERT_SVH
`define DEX_CLASS_DATA_STREAM_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, off during reset
`define DCDSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcdsp check failed");

// Next-cycle implication, active during reset
`define DCDSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dcdsp check failed");

`endif

FILE: sv/dcdsp_pkg.sv
// Shared types and constants for the class data stream parser
package dcdsp_pkg;

  localparam int VAL_W           = 32;
  localparam int MAX_VALUE_BYTES = 5;
  localparam int BYTE_CNT_W      = 3;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = 2;
  localparam int FIFO_CNT_W      = 3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_FIELDS  = 3'd2,
    PH_DIRECT  = 3'd3,
    PH_VIRTUAL = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef struct packed {
    logic             restart;
    logic [VAL_W-1:0] value;
  } value_item_t;

  typedef struct packed {
    logic             last;
    logic             is_virtual;
    logic [VAL_W-1:0] code_offset;
    logic [VAL_W-1:0] access_flags;
    logic [VAL_W-1:0] method_index;
  } record_t;

endpackage

FILE: sv/dcdsp_uleb_front.sv
// ULEB128 front end: accepts bytes and pushes completed values
module dcdsp_uleb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data,
  input  logic                  in_first,
  output logic                  push_valid,
  input  logic                  push_ready,
  output dcdsp_pkg::value_item_t push_item
);
  import dcdsp_pkg::*;

  logic [VAL_W-1:0]      accum;
  logic [BYTE_CNT_W-1:0] cnt;
  logic                  pend;

  logic [VAL_W-1:0]      base_accum;
  logic [BYTE_CNT_W-1:0] base_cnt;
  logic [VAL_W-1:0]      payload;
  logic [VAL_W-1:0]      shifted;
  logic [VAL_W-1:0]      accum_sum;
  logic                  ends;
  logic                  accept;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign base_accum = in_first ? '0 : accum;
  assign base_cnt   = in_first ? '0 : cnt;
  assign payload    = {{(VAL_W-7){1'b0}}, in_data[6:0]};

  always_comb begin
    case (base_cnt)
      3'd0:    shifted = payload;
      3'd1:    shifted = payload << 7;
      3'd2:    shifted = payload << 14;
      3'd3:    shifted = payload << 21;
      3'd4:    shifted = payload << 28;
      default: shifted = '0;
    endcase
  end

  assign accum_sum = base_accum | shifted;
  assign ends      = !in_data[7] || (base_cnt == BYTE_CNT_W'(MAX_VALUE_BYTES - 1));

  assign push_valid        = in_valid && ends;
  assign push_item.restart = in_first | pend;
  assign push_item.value   = accum_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
      cnt   <= '0;
      pend  <= 1'b0;
    end else if (accept) begin
      if (ends) begin
        accum <= '0;
        cnt   <= '0;
        pend  <= 1'b0;
      end else begin
        accum <= accum_sum;
        cnt   <= base_cnt + 3'd1;
        pend  <= in_first | pend;
      end
    end
  end

endmodule

FILE: sv/dcdsp_value_fifo.sv
// Short queue of decoded values between front and back
module dcdsp_value_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_valid,
  output logic                   wr_ready,
  input  dcdsp_pkg::value_item_t wr_item,
  output logic                   rd_valid,
  input  logic                   rd_ready,
  output dcdsp_pkg::value_item_t rd_item
);
  import dcdsp_pkg::*;

  value_item_t           mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign wr_ready = (count != FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 3'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 3'd1;
      end
    end
  end

endmodule

FILE: sv/dcdsp_method_back.sv
// Back end: walks header, fields and method lists and emits method records
module dcdsp_method_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dcdsp_pkg::value_item_t in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dcdsp_pkg::record_t     out_rec
);
  import dcdsp_pkg::*;

  phase_t           phase, phase_next;
  logic [1:0]       header_slot, header_slot_next;
  logic [VAL_W-1:0] static_count, static_count_next;
  logic [VAL_W-1:0] field_total, field_total_next;
  logic [VAL_W:0]   field_left, field_left_next;
  logic [VAL_W-1:0] direct_count, direct_count_next;
  logic [VAL_W-1:0] virtual_count, virtual_count_next;
  logic [VAL_W-1:0] methods_left, methods_left_next;
  logic [1:0]       method_slot, method_slot_next;
  logic [VAL_W-1:0] index_sum, index_sum_next;
  logic [VAL_W-1:0] held_access, held_access_next;
  record_t          rec_next;

  logic             take;
  logic             emit;
  logic             start_m;
  logic             virt;
  logic [VAL_W-1:0] v;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign v        = in_item.value;

  always_comb begin
    phase_next         = phase;
    header_slot_next   = header_slot;
    static_count_next  = static_count;
    field_total_next   = field_total;
    field_left_next    = field_left;
    direct_count_next  = direct_count;
    virtual_count_next = virtual_count;
    methods_left_next  = methods_left;
    method_slot_next   = method_slot;
    index_sum_next     = index_sum;
    held_access_next   = held_access;
    rec_next           = out_rec;
    emit               = 1'b0;
    start_m            = 1'b0;
    virt               = 1'b0;
    if (take) begin
      if (in_item.restart) begin
        phase_next         = PH_HEADER;
        header_slot_next   = '0;
        static_count_next  = '0;
        field_total_next   = '0;
        field_left_next    = '0;
        direct_count_next  = '0;
        virtual_count_next = '0;
        methods_left_next  = '0;
        method_slot_next   = '0;
        index_sum_next     = '0;
        held_access_next   = '0;
      end
      unique case (phase_next)
        PH_HEADER: begin
          case (header_slot_next)
            2'd0: begin
              static_count_next = v;
              header_slot_next  = 2'd1;
            end
            2'd1: begin
              field_total_next = static_count_next + v;
              header_slot_next = 2'd2;
            end
            2'd2: begin
              direct_count_next = v;
              header_slot_next  = 2'd3;
            end
            default: begin
              virtual_count_next = v;
              header_slot_next   = 2'd0;
              field_left_next    = {field_total_next, 1'b0};
              if (field_total_next != '0) begin
                phase_next = PH_FIELDS;
              end else begin
                start_m = 1'b1;
              end
            end
          endcase
        end
        PH_FIELDS: begin
          if (field_left_next != '0) begin
            field_left_next = field_left_next - 33'd1;
          end
          if (field_left_next == '0) begin
            start_m = 1'b1;
          end
        end
        PH_DIRECT, PH_VIRTUAL: begin
          case (method_slot_next)
            2'd0: begin
              index_sum_next   = index_sum_next + v;
              method_slot_next = 2'd1;
            end
            2'd1: begin
              held_access_next = v;
              method_slot_next = 2'd2;
            end
            default: begin
              virt                  = (phase_next == PH_VIRTUAL);
              emit                  = 1'b1;
              rec_next.method_index = index_sum_next;
              rec_next.access_flags = held_access_next;
              rec_next.code_offset  = v;
              rec_next.is_virtual   = virt;
              rec_next.last         = (methods_left_next <= 32'd1) &&
                                      (virt || (virtual_count_next == '0));
              method_slot_next      = 2'd0;
              if (methods_left_next != '0) begin
                methods_left_next = methods_left_next - 32'd1;
              end
              if (methods_left_next == '0) begin
                if (!virt && (virtual_count_next != '0)) begin
                  phase_next        = PH_VIRTUAL;
                  methods_left_next = virtual_count_next;
                  index_sum_next    = '0;
                end else begin
                  phase_next = PH_DONE;
                end
              end
            end
          endcase
        end
        default: begin
        end
      endcase
      if (start_m) begin
        method_slot_next = '0;
        index_sum_next   = '0;
        if (direct_count_next != '0) begin
          phase_next        = PH_DIRECT;
          methods_left_next = direct_count_next;
        end else if (virtual_count_next != '0) begin
          phase_next        = PH_VIRTUAL;
          methods_left_next = virtual_count_next;
        end else begin
          phase_next        = PH_DONE;
          methods_left_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_slot   <= '0;
      static_count  <= '0;
      field_total   <= '0;
      field_left    <= '0;
      direct_count  <= '0;
      virtual_count <= '0;
      methods_left  <= '0;
      method_slot   <= '0;
      index_sum     <= '0;
      held_access   <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      header_slot   <= header_slot_next;
      static_count  <= static_count_next;
      field_total   <= field_total_next;
      field_left    <= field_left_next;
      direct_count  <= direct_count_next;
      virtual_count <= virtual_count_next;
      methods_left  <= methods_left_next;
      method_slot   <= method_slot_next;
      index_sum     <= index_sum_next;
      held_access   <= held_access_next;
      if (take) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_rec <= rec_next;
    end
  end

endmodule

FILE: sv/dex_class_data_stream_parser_core.sv
// Top level of the class data stream parser
//
//   channel  dir  tdata                       tuser        tlast
//   s_axis   in   data_byte                   first        -
//   m_axis   out  method_index, access_flags, is_virtual   last
//                 code_offset
//
// One byte per cycle in while the queue has room; a decoded value passes the
// 4-entry queue, and the method walker takes one value per cycle while its output
// is not held. The closing value is registered in the queue, the record at the output.
// Reset clears all control state and the queue; the block is ready the cycle after.
// A stalled output holds the walker; bytes keep flowing until the queue fills.
module dex_class_data_stream_parser_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic         s_axis_tuser,  // [0] first
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // [31:0] method_index, [63:32] access_flags,
                                      // [95:64] code_offset
  output logic         m_axis_tuser,  // [0] is_virtual
  output logic         m_axis_tlast
);
  import dcdsp_pkg::*;

  logic        push_valid;
  logic        push_ready;
  value_item_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  value_item_t pop_item;
  record_t     rec;

  dcdsp_uleb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_first   (s_axis_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  dcdsp_value_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  dcdsp_method_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop_valid),
    .in_ready  (pop_ready),
    .in_item   (pop_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (rec)
  );

  assign m_axis_tdata = {rec.code_offset, rec.access_flags, rec.method_index};
  assign m_axis_tuser = rec.is_virtual;
  assign m_axis_tlast = rec.last;

endmodule

FILE: sv/dex_class_data_stream_parser_core_checker.sv
// Port-level checks for the class data stream parser, bound to the top level
`include "dex_class_data_stream_parser_core_assert.svh"

module dex_class_data_stream_parser_core_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  `DCDSP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready && !rst, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  `DCDSP_ASSERT_NEXT(a_reset_clean, rst, s_axis_tready && !m_axis_tvalid)
  `DCDSP_ASSERT_IMPL(a_full_only_on_stall, !s_axis_tready, $past(m_axis_tvalid && !m_axis_tready))

endmodule

bind dex_class_data_stream_parser_core dex_class_data_stream_parser_core_checker u_checker (.*);
